// ===== hw/rtl/adc_average_to_bcd_display_core_assert.svh =====
// Assertion macros shared by the voltmeter RTL.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef ADC_AVERAGE_TO_BCD_DISPLAY_CORE_ASSERT_SVH
`define ADC_AVERAGE_TO_BCD_DISPLAY_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ADC_AVG_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ADC_AVG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/adc_avg_pkg.sv =====
package adc_avg_pkg;

	// Item kind carried on the slave-side tuser.
	localparam logic FUNC_SAMPLE = 1'b0;
	localparam logic FUNC_TICK   = 1'b1;

	// Refresh ticks per start-conversion pulse, minus one.
	localparam logic [4:0] TICK_LAST = 5'd25;

	// Scaling of the average to tenths of a volt: (avg * 33 + 511) / 1023.
	localparam logic [15:0] SCALE_MUL  = 16'd33;
	localparam logic [15:0] ROUND_OFS  = 16'd511;
	localparam logic [10:0] FULL_SCALE = 11'd1023;
	localparam logic [5:0]  DEC_BASE   = 6'd10;

	// One display result.
	typedef struct packed {
		logic [6:0] segments;
		logic       digit_select;
		logic       start_conversion;
	} disp_res_t;

	// Seven-segment pattern, bit 0 is segment a. Codes above nine show a nine.
	function automatic logic [6:0] seg_pattern(input logic [3:0] digit);
		logic [6:0] pat;
		case (digit)
			4'd0: pat = 7'h3F;
			4'd1: pat = 7'h06;
			4'd2: pat = 7'h5B;
			4'd3: pat = 7'h4F;
			4'd4: pat = 7'h66;
			4'd5: pat = 7'h6D;
			4'd6: pat = 7'h7D;
			4'd7: pat = 7'h07;
			4'd8: pat = 7'h7F;
			default: pat = 7'h67;
		endcase
		return pat;
	endfunction

endpackage

// ===== hw/rtl/adc_avg_accum.sv =====
// Sums converter readings in groups and hands each finished group sum onward.
module adc_avg_accum #(
	parameter int SAMPLES_PER_GROUP = 8,
	localparam int SUM_W = 10 + $clog2(SAMPLES_PER_GROUP),
	localparam int COUNT_W = (SAMPLES_PER_GROUP > 1) ? $clog2(SAMPLES_PER_GROUP) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_en,
	input  logic [9:0]       sample,
	output logic             grp_done,
	output logic [SUM_W-1:0] grp_sum
);

	logic [SUM_W-1:0]   sum_q;
	logic [COUNT_W-1:0] count_q;

	assign grp_sum  = sum_q + SUM_W'(sample);
	assign grp_done = sample_en && (count_q == COUNT_W'(SAMPLES_PER_GROUP - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
		end else if (sample_en) begin
			if (grp_done) begin
				sum_q   <= '0;
				count_q <= '0;
			end else begin
				sum_q   <= grp_sum;
				count_q <= count_q + COUNT_W'(1);
			end
		end
	end

endmodule

// ===== hw/rtl/adc_avg_conv.sv =====
// Turns a finished group sum into the two BCD digits on display. The average comes
// from a reciprocal multiply, is scaled to tenths of a volt and split into digits,
// and the value is stored at the edge that closes the group.
module adc_avg_conv #(
	parameter int SAMPLES_PER_GROUP = 8,
	localparam int SUM_W = 10 + $clog2(SAMPLES_PER_GROUP)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             grp_done,
	input  logic [SUM_W-1:0] grp_sum,
	output logic [7:0]       shown
);

	// floor(x / N) == (x * ceil(2^K / N)) >> K for x < 2^SUM_W when 2^(K-SUM_W) >= N.
	localparam int DIV_SH  = SUM_W + $clog2(SAMPLES_PER_GROUP);
	localparam int RECIP   = ((2 ** DIV_SH) + SAMPLES_PER_GROUP - 1) / SAMPLES_PER_GROUP;
	localparam int RECIP_W = DIV_SH + 1;
	localparam int PROD_W  = SUM_W + RECIP_W;

	logic [7:0]        shown_q;
	logic [PROD_W-1:0] prod;
	logic [9:0]        avg;
	logic [15:0]       scaled;
	logic [5:0]        quot0;
	logic [10:0]       rem0;
	logic [5:0]        volts;
	logic [1:0]        tens;
	logic [5:0]        units;

	assign prod = PROD_W'(grp_sum) * PROD_W'(RECIP_W'(RECIP));
	assign avg  = prod[DIV_SH +: 10];

	always_comb begin
		scaled = 16'(avg) * adc_avg_pkg::SCALE_MUL + adc_avg_pkg::ROUND_OFS;
		// x = q*1024 + r = q*1023 + (q + r), and q + r stays below twice 1023.
		quot0  = scaled[15:10];
		rem0   = 11'(scaled[9:0]) + 11'(quot0);
		volts  = (rem0 >= adc_avg_pkg::FULL_SCALE) ? quot0 + 6'd1 : quot0;
		if (volts >= 6'd30) begin
			tens = 2'd3;
		end else if (volts >= 6'd20) begin
			tens = 2'd2;
		end else if (volts >= adc_avg_pkg::DEC_BASE) begin
			tens = 2'd1;
		end else begin
			tens = 2'd0;
		end
		units = volts - 6'(tens) * adc_avg_pkg::DEC_BASE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shown_q <= '0;
		end else if (grp_done) begin
			shown_q <= {2'b00, tens, units[3:0]};
		end
	end

	assign shown = shown_q;

endmodule

// ===== hw/rtl/adc_avg_disp.sv =====
// Display multiplexing: picks the digit for each refresh tick, alternating
// tens and units, and raises the start pulse once every 26 ticks.
module adc_avg_disp (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   tick_en,
	input  logic [7:0]             shown,
	output adc_avg_pkg::disp_res_t res
);

	logic [4:0] tick_count_q;
	logic       high_next_q;
	logic       at_last;
	logic [3:0] digit;

	assign at_last = (tick_count_q == adc_avg_pkg::TICK_LAST);
	assign digit   = high_next_q ? shown[7:4] : shown[3:0];

	assign res.segments         = adc_avg_pkg::seg_pattern(digit);
	assign res.digit_select     = high_next_q;
	assign res.start_conversion = at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q <= '0;
			high_next_q  <= 1'b1;
		end else if (tick_en) begin
			tick_count_q <= at_last ? 5'd0 : tick_count_q + 5'd1;
			high_next_q  <= !high_next_q;
		end
	end

endmodule

// ===== hw/rtl/adc_average_to_bcd_display_core.sv =====
// Channel  Dir  tdata                                   tuser
// s_*      in   [9:0] sample, [15:10] zero              [0] func (0 sample, 1 tick)
// m_*      out  [6:0] segments, [7] start_conversion    [0] digit_select (1 tens)
//
// Every request passes an input register; a tick moves on to the output register
// when free, a sample gives no result. A new request can be taken in every cycle
// unless a tick stalls. A sample that closes a group is averaged, scaled and stored
// in the cycle it leaves the input register, so a tick right behind it sees the value.
// arst_n clears all control state; the display starts on the tens digit showing 00.
// A stalled master side holds a tick in the input register and stops the slave side.

`include "adc_average_to_bcd_display_core_assert.svh"

module adc_average_to_bcd_display_core #(
	parameter int SAMPLES_PER_GROUP = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [9:0] sample, [15:10] unused
	input  logic        s_tuser,   // [0] func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [6:0] segments, [7] start_conversion
	output logic        m_tuser    // [0] digit_select
);

	localparam int SUM_W = 10 + $clog2(SAMPLES_PER_GROUP);

	// Input register.
	logic       in_valid_s1;
	logic       func_s1;
	logic [9:0] sample_s1;

	// Output register.
	logic                   m_tvalid_q;
	adc_avg_pkg::disp_res_t res_q;

	logic                   in_acc;
	logic                   tick_s1;
	logic                   out_free;
	logic                   fire_s1;
	logic                   sample_en;
	logic                   tick_en;
	logic                   grp_done;
	logic [SUM_W-1:0]       grp_sum;
	logic [7:0]             shown;
	adc_avg_pkg::disp_res_t disp_res;

	// A tick needs a free output register. The displayed value is always current,
	// since a closing sample stores it at the edge where it leaves the input register.
	// Samples always move on.
	assign tick_s1   = (func_s1 == adc_avg_pkg::FUNC_TICK);
	assign out_free  = !m_tvalid_q || m_tready;
	assign fire_s1   = in_valid_s1 && (!tick_s1 || out_free);
	assign sample_en = fire_s1 && !tick_s1;
	assign tick_en   = fire_s1 && tick_s1;

	assign s_tready = !in_valid_s1 || fire_s1;
	assign in_acc   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (in_acc) begin
				in_valid_s1 <= 1'b1;
			end else if (fire_s1) begin
				in_valid_s1 <= 1'b0;
			end
			if (tick_en) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_s1   <= s_tuser;
			sample_s1 <= s_tdata[9:0];
		end
		if (tick_en) begin
			res_q <= disp_res;
		end
	end

	adc_avg_accum #(
		.SAMPLES_PER_GROUP(SAMPLES_PER_GROUP)
	) u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample_en(sample_en),
		.sample   (sample_s1),
		.grp_done (grp_done),
		.grp_sum  (grp_sum)
	);

	adc_avg_conv #(
		.SAMPLES_PER_GROUP(SAMPLES_PER_GROUP)
	) u_conv (
		.clk     (clk),
		.arst_n  (arst_n),
		.grp_done(grp_done),
		.grp_sum (grp_sum),
		.shown   (shown)
	);

	adc_avg_disp u_disp (
		.clk    (clk),
		.arst_n (arst_n),
		.tick_en(tick_en),
		.shown  (shown),
		.res    (disp_res)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {res_q.start_conversion, res_q.segments};
	assign m_tuser  = res_q.digit_select;

	// A tick is only taken when the output register can hold its result.
	`ADC_AVG_ASSERT_SAME(a_tick_needs_room, tick_en, out_free, "tick taken into a full output")
	// A request that cannot move on stays unchanged in the input register.
	`ADC_AVG_ASSERT_NEXT(a_input_held, in_valid_s1 && !fire_s1,
		in_valid_s1 && $stable(func_s1) && $stable(sample_s1), "waiting request changed")
	// Only ticks load a result; a sample leaves the output side untouched.
	`ADC_AVG_ASSERT_NEXT(a_sample_no_result, sample_en && !tick_en && m_tvalid_q && !m_tready,
		m_tvalid_q && $stable(res_q), "sample disturbed a pending result")

endmodule

// ===== sim/testbench.sv =====
module testbench;

	localparam int GROUP_SIZE = 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int FAULTS_SHOWN = 10;

	// Segment patterns for the digits 0 to 9, seven bits each, digit 0 in the lowest bits.
	localparam logic [69:0] DIGIT_GLYPHS = {
		7'h67, 7'h7F, 7'h07, 7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
	};

	// Ways in which the display side takes results.
	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_PERIODIC
	} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        s_tuser = adc_avg_pkg::FUNC_SAMPLE;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tuser;

	// Expected state of the voltmeter, kept at the block's widths.
	logic [12:0] acc_sum = '0;
	logic [3:0]  acc_count = '0;
	logic [7:0]  shown_bcd = '0;
	logic        tens_next = 1'b1;
	logic [4:0]  refresh_count = '0;
	adc_avg_pkg::disp_res_t pending_digits[$];

	int unsigned faults = 0;
	int unsigned cycles = 0;
	int unsigned items_sent = 0;
	int unsigned burst_left = 0;

	rx_mode_t    rx_mode = RX_OPEN;
	int unsigned rx_mode_left = 0;
	int unsigned rx_phase = 0;

	adc_average_to_bcd_display_core #(
		.SAMPLES_PER_GROUP(GROUP_SIZE)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Applies one accepted request to the expected state. A sample adds to the group and,
	// when the group is full, replaces the shown value; a tick yields one digit to show.
	task automatic advance_voltmeter(input logic func, input logic [9:0] reading);
		int unsigned tenths;
		logic [3:0]  tens_d;
		logic [3:0]  units_d;
		logic [3:0]  digit;
		adc_avg_pkg::disp_res_t res;
		if (func == adc_avg_pkg::FUNC_SAMPLE) begin
			acc_sum = acc_sum + 13'(reading);
			acc_count = acc_count + 4'd1;
			if (acc_count == GROUP_SIZE) begin
				tenths = ((acc_sum / GROUP_SIZE) * 33 + 511) / 1023;
				tens_d = 4'(tenths / 10);
				units_d = 4'(tenths % 10);
				shown_bcd = {tens_d, units_d};
				acc_sum = '0;
				acc_count = '0;
			end
		end else begin
			res.digit_select = tens_next;
			res.start_conversion = (refresh_count == adc_avg_pkg::TICK_LAST);
			refresh_count = res.start_conversion ? 5'd0 : refresh_count + 5'd1;
			digit = tens_next ? shown_bcd[7:4] : shown_bcd[3:0];
			if (digit > 4'd9) begin
				digit = 4'd9;
			end
			res.segments = DIGIT_GLYPHS[digit * 7 +: 7];
			pending_digits.push_back(res);
			tens_next = !tens_next;
		end
	endtask

	// Both sides are observed at the rising edge; accepted requests are predicted
	// before the results of the same edge are compared.
	always @(posedge clk) begin : display_monitor
		adc_avg_pkg::disp_res_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				advance_voltmeter(s_tuser, s_tdata[9:0]);
			end
			if (m_tvalid && m_tready) begin
				if (pending_digits.size() == 0) begin
					faults++;
					if (faults <= FAULTS_SHOWN) begin
						$display("unexpected result: seg %h sel %b start %b",
							m_tdata[6:0], m_tuser, m_tdata[7]);
					end
				end else begin
					want = pending_digits.pop_front();
					if (m_tdata[6:0] !== want.segments || m_tuser !== want.digit_select ||
							m_tdata[7] !== want.start_conversion) begin
						faults++;
						if (faults <= FAULTS_SHOWN) begin
							$display("mismatch: expected seg %h sel %b start %b, got seg %h sel %b start %b",
								want.segments, want.digit_select, want.start_conversion,
								m_tdata[6:0], m_tuser, m_tdata[7]);
						end
					end
				end
			end
		end
	end

	// The display side switches between open, random, sparse and periodic acceptance.
	always @(negedge clk) begin
		if (rx_mode_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_mode_left = $urandom_range(20, 200);
		end else begin
			rx_mode_left--;
		end
		rx_phase++;
		case (rx_mode)
			RX_OPEN: m_tready <= 1'b1;
			RX_COIN: m_tready <= $urandom_range(0, 1);
			RX_SPARSE: m_tready <= ($urandom_range(0, 7) == 0);
			default: m_tready <= ((rx_phase % 16) < 9);
		endcase
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Offers one request at the falling edge and holds it until it is taken. Requests come
	// in bursts; between bursts the valid line drops for a random number of cycles.
	task automatic send_item(input logic func, input logic [9:0] reading);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
				: $urandom_range(1, 10);
		end
		s_tvalid <= 1'b1;
		s_tuser <= func;
		s_tdata <= {6'b0, reading};
		do begin
			@(posedge clk);
		end while (!s_tready);
		@(negedge clk);
		burst_left--;
		items_sent++;
	endtask

	task automatic send_tick();
		send_item(adc_avg_pkg::FUNC_TICK, 10'($urandom_range(0, 1023)));
	endtask

	// Full-scale readings must show 3.3 and zero readings 0.0, on both digits.
	task automatic test_scale_extremes();
		repeat (GROUP_SIZE) send_item(adc_avg_pkg::FUNC_SAMPLE, 10'h3FF);
		send_item(adc_avg_pkg::FUNC_TICK, 10'h000);
		send_item(adc_avg_pkg::FUNC_TICK, 10'h3FF);
		repeat (GROUP_SIZE) send_item(adc_avg_pkg::FUNC_SAMPLE, 10'h000);
		send_item(adc_avg_pkg::FUNC_TICK, 10'h3FF);
		send_item(adc_avg_pkg::FUNC_TICK, 10'h000);
	endtask

	// Whole groups around a chosen level, with ticks inside and after each group. Some
	// levels are aimed at each tenth of a volt so that every digit shows up.
	task automatic test_level_groups(input int unsigned quota);
		int unsigned first;
		int unsigned pick;
		int level;
		int spread;
		int value;
		first = items_sent;
		while (items_sent - first < quota) begin
			pick = $urandom_range(0, 9);
			if (pick < 4) begin
				level = ($urandom_range(0, 33) * 1023) / 33;
			end else if (pick < 8) begin
				level = $urandom_range(0, 1023);
			end else begin
				level = $urandom_range(0, 1) ? 1023 : 0;
			end
			case ($urandom_range(0, 3))
				0: spread = 0;
				1: spread = 1023;
				default: spread = $urandom_range(1, 64);
			endcase
			repeat (GROUP_SIZE) begin
				value = level + $urandom_range(0, 2 * spread) - spread;
				if (value < 0) begin
					value = 0;
				end else if (value > 1023) begin
					value = 1023;
				end
				send_item(adc_avg_pkg::FUNC_SAMPLE, 10'(value));
				if ($urandom_range(0, 5) == 0) begin
					send_tick();
				end
			end
			repeat ($urandom_range(1, 6)) send_tick();
		end
	endtask

	// Long runs of ticks wrap the start-conversion count many times; stray samples
	// between runs shift the group boundary.
	task automatic test_tick_runs(input int unsigned quota);
		int unsigned first;
		first = items_sent;
		while (items_sent - first < quota) begin
			repeat ($urandom_range(1, 80)) send_tick();
			repeat ($urandom_range(0, 3)) begin
				send_item(adc_avg_pkg::FUNC_SAMPLE, 10'($urandom_range(0, 1023)));
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_scale_extremes();
		test_level_groups(1330);
		test_tick_runs(400);
		s_tvalid <= 1'b0;
		while (pending_digits.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		if (faults == 0 && pending_digits.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
